### rtl/hpsd_pkg.sv
`timescale 1ns / 1ps
// hpsd_pkg: beat types, operation codes and the microcode table of the heap pop unit
// no dependencies; used by heap_pop_sift_down_unit

package hpsd_pkg;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_POP   = 2'd2;
   localparam logic [1:0] FUNC_NOP   = 2'd3;

   typedef struct packed {
      logic [1:0]          func;
      logic [9:0]          index;
      logic signed [31:0]  value;
      logic [10:0]         heap_size;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  result_value;
      logic                moved;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_WRITE,
      ST_READ,
      ST_READ_DATA,
      ST_POP,
      ST_POP_ROOT,
      ST_POP_LAST,
      ST_LEVEL,
      ST_LEFT,
      ST_PICK,
      ST_FINAL,
      ST_DONE
   } step_type;

   typedef enum logic [3:0] {
      COND_NONE,
      COND_NO_REQ,
      COND_DISPATCH,
      COND_N_ZERO,
      COND_N_LT2,
      COND_LAST_NOT_LESS,
      COND_C_GE_M,
      COND_NO_SIFT,
      COND_RSP_BUSY
   } cond_type;

   typedef enum logic [2:0] {
      RD_INDEX,
      RD_ROOT,
      RD_LAST,
      RD_CHILD,
      RD_SIBLING
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_INDEX,
      WR_LAST,
      WR_HOLE,
      WR_FINAL
   } wr_sel_type;

   typedef enum logic [1:0] {
      CAP_NONE,
      CAP_ROOT,
      CAP_LAST,
      CAP_CHILD
   } cap_type;

   typedef enum logic [2:0] {
      RES_KEEP,
      RES_CLEAR,
      RES_VALUE,
      RES_RDATA,
      RES_RDATA_GATED
   } res_type;

   typedef enum logic [1:0] {
      PTR_NONE,
      PTR_INIT,
      PTR_DESCEND
   } ptr_type;

   typedef struct packed {
      logic       accept;
      cond_type   cond;
      step_type   next;
      step_type   target;
      rd_sel_type rd;
      wr_sel_type wr;
      cap_type    cap;
      res_type    res;
      ptr_type    ptr;
      logic       set_moved;
   } ctl_type;

   // control store, one word per step; jump to target on cond, dispatch goes by func
   function automatic ctl_type ucode_rom(input step_type step);
      ctl_type w;
      w = '{accept: 1'b0, cond: COND_NONE, next: ST_IDLE, target: ST_IDLE,
            rd: RD_INDEX, wr: WR_NONE, cap: CAP_NONE, res: RES_KEEP,
            ptr: PTR_NONE, set_moved: 1'b0};
      case (step)
         ST_IDLE: begin
            w.accept = 1'b1;
            w.cond   = COND_NO_REQ;
            w.target = ST_IDLE;
            w.next   = ST_DECODE;
         end
         ST_DECODE: begin
            w.cond = COND_DISPATCH;
            w.res  = RES_CLEAR;
         end
         ST_WRITE: begin
            w.wr   = WR_INDEX;
            w.res  = RES_VALUE;
            w.next = ST_DONE;
         end
         ST_READ: begin
            w.rd   = RD_INDEX;
            w.next = ST_READ_DATA;
         end
         ST_READ_DATA: begin
            w.res  = RES_RDATA_GATED;
            w.next = ST_DONE;
         end
         ST_POP: begin
            w.rd     = RD_ROOT;
            w.cond   = COND_N_ZERO;
            w.target = ST_DONE;
            w.next   = ST_POP_ROOT;
         end
         ST_POP_ROOT: begin
            w.cap    = CAP_ROOT;
            w.res    = RES_RDATA;
            w.rd     = RD_LAST;
            w.cond   = COND_N_LT2;
            w.target = ST_DONE;
            w.next   = ST_POP_LAST;
         end
         ST_POP_LAST: begin
            w.cap    = CAP_LAST;
            w.wr     = WR_LAST;
            w.ptr    = PTR_INIT;
            w.cond   = COND_LAST_NOT_LESS;
            w.target = ST_DONE;
            w.next   = ST_LEVEL;
         end
         ST_LEVEL: begin
            w.rd     = RD_CHILD;
            w.cond   = COND_C_GE_M;
            w.target = ST_FINAL;
            w.next   = ST_LEFT;
         end
         ST_LEFT: begin
            w.cap  = CAP_CHILD;
            w.rd   = RD_SIBLING;
            w.next = ST_PICK;
         end
         ST_PICK: begin
            w.wr     = WR_HOLE;
            w.ptr    = PTR_DESCEND;
            w.cond   = COND_NO_SIFT;
            w.target = ST_FINAL;
            w.next   = ST_LEVEL;
         end
         ST_FINAL: begin
            w.wr        = WR_FINAL;
            w.set_moved = 1'b1;
            w.next      = ST_DONE;
         end
         ST_DONE: begin
            w.cond   = COND_RSP_BUSY;
            w.target = ST_DONE;
            w.next   = ST_IDLE;
         end
         default: begin
            w.next = ST_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

### rtl/hpsd_ram.sv
`timescale 1ns / 1ps
// hpsd_ram: generic single-write, single-read memory with registered read data
// no dependencies

module hpsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/heap_pop_sift_down_unit.sv
`timescale 1ns / 1ps
// heap_pop_sift_down_unit: top level, microcoded sequencer over a heap store
// depends on hpsd_pkg and hpsd_ram
//
// Usage:
//   req channel (req_valid/req_ready/req_data) carries one operation per beat:
//   write an entry, read an entry, pop the max-heap held in the first heap_size
//   entries, or no-op. rsp channel (rsp_valid/rsp_ready/rsp_data) returns one
//   beat per request: written value, read data, or popped root with moved flag.
//   A pop walks down the heap level by level; each level reads the children
//   one at a time because the store has one read port. A pop of an empty or
//   one-entry heap skips the walk.
//   One request is in flight at a time; req_ready is high only in the idle step.
//   A finished response sits in the output register, and the next request is
//   taken while it waits; a stalled receiver holds the sequencer in its last
//   step only once a second response is ready.
//   Reset returns the sequencer to idle and clears the output valid flag; the
//   store is not cleared and entries read back only once written.

module heap_pop_sift_down_unit
   import hpsd_pkg::*;
#(
   parameter int HEAP_DEPTH = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int CW = AW + 2;

   step_type step_ff, step_in;
   ctl_type  ctl;
   logic     jump, act, accept;

   logic [1:0]         func_ff;
   logic [AW-1:0]      index_ff;
   logic signed [31:0] value_ff;
   logic               in_range_ff;
   logic [AW-1:0]      m_ff;
   logic               n_zero_ff, n_lt2_ff;

   logic signed [31:0] root_ff, last_ff, cval_ff, result_ff;
   logic               moved_ff;
   logic [AW-1:0]      p_ff;
   logic [CW-1:0]      c_ff;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [31:0]        n_wide, n_sat;
   logic signed [31:0] rd_data;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [31:0]        wr_data;
   logic               wr_en;
   logic [CW-1:0]      sib_idx, chosen_idx;
   logic signed [31:0] chosen_val;
   logic               sib_ok;

   assign ctl       = ucode_rom(step_ff);
   assign req_ready = ctl.accept;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign n_wide = {21'd0, req_data.heap_size};
   assign n_sat  = (n_wide > 32'(HEAP_DEPTH)) ? 32'(HEAP_DEPTH) : n_wide;

   // child choice for the current level
   assign sib_idx    = c_ff + CW'(1);
   assign sib_ok     = sib_idx < CW'(m_ff);
   assign chosen_val = (sib_ok && (cval_ff < rd_data)) ? rd_data : cval_ff;
   assign chosen_idx = (sib_ok && (cval_ff < rd_data)) ? sib_idx : c_ff;

   // condition select and step sequencing
   always_comb begin
      jump    = 1'b0;
      step_in = ctl.next;
      case (ctl.cond)
         COND_NONE:          jump = 1'b0;
         COND_NO_REQ:        jump = !req_valid;
         COND_DISPATCH:      jump = 1'b1;
         COND_N_ZERO:        jump = n_zero_ff;
         COND_N_LT2:         jump = n_lt2_ff;
         COND_LAST_NOT_LESS: jump = !(rd_data < root_ff);
         COND_C_GE_M:        jump = c_ff >= CW'(m_ff);
         COND_NO_SIFT:       jump = !(last_ff < chosen_val);
         COND_RSP_BUSY:      jump = rsp_valid_ff && !rsp_ready;
         default:            jump = 1'b0;
      endcase
      if (ctl.cond == COND_DISPATCH) begin
         case (func_ff)
            FUNC_WRITE: step_in = ST_WRITE;
            FUNC_READ:  step_in = ST_READ;
            FUNC_POP:   step_in = ST_POP;
            default:    step_in = ST_DONE;
         endcase
      end else if (jump) begin
         step_in = ctl.target;
      end
   end

   assign act = !jump;

   // memory port selection
   always_comb begin
      case (ctl.rd)
         RD_INDEX:   rd_addr = index_ff;
         RD_ROOT:    rd_addr = '0;
         RD_LAST:    rd_addr = m_ff;
         RD_CHILD:   rd_addr = c_ff[AW-1:0];
         RD_SIBLING: rd_addr = sib_idx[AW-1:0];
         default:    rd_addr = index_ff;
      endcase
      wr_en   = 1'b0;
      wr_addr = p_ff;
      wr_data = last_ff;
      case (ctl.wr)
         WR_NONE: begin
            wr_en = 1'b0;
         end
         WR_INDEX: begin
            wr_en   = in_range_ff;
            wr_addr = index_ff;
            wr_data = value_ff;
         end
         WR_LAST: begin
            wr_en   = act;
            wr_addr = m_ff;
            wr_data = root_ff;
         end
         WR_HOLE: begin
            wr_en   = act;
            wr_addr = p_ff;
            wr_data = chosen_val;
         end
         WR_FINAL: begin
            wr_en   = act;
            wr_addr = p_ff;
            wr_data = last_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   hpsd_ram #(
      .WIDTH (32),
      .DEPTH (HEAP_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (step_ff == ST_DONE && act) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff     <= req_data.func;
         index_ff    <= AW'(req_data.index);
         value_ff    <= req_data.value;
         in_range_ff <= {22'd0, req_data.index} < 32'(HEAP_DEPTH);
         n_zero_ff   <= n_sat == 32'd0;
         n_lt2_ff    <= n_sat < 32'd2;
         m_ff        <= AW'(n_sat - 32'd1);
      end
      case (ctl.cap)
         CAP_ROOT:  root_ff <= rd_data;
         CAP_LAST:  last_ff <= rd_data;
         CAP_CHILD: cval_ff <= rd_data;
         default:   ;
      endcase
      case (ctl.res)
         RES_CLEAR: begin
            result_ff <= '0;
            moved_ff  <= 1'b0;
         end
         RES_VALUE:       result_ff <= value_ff;
         RES_RDATA:       result_ff <= rd_data;
         RES_RDATA_GATED: result_ff <= in_range_ff ? rd_data : 32'sd0;
         default:         ;
      endcase
      if (ctl.set_moved) begin
         moved_ff <= 1'b1;
      end
      if (act) begin
         case (ctl.ptr)
            PTR_INIT: begin
               p_ff <= '0;
               c_ff <= CW'(1);
            end
            PTR_DESCEND: begin
               p_ff <= chosen_idx[AW-1:0];
               c_ff <= CW'({chosen_idx[AW-1:0], 1'b1});
            end
            default: ;
         endcase
      end
      if (step_ff == ST_DONE && act) begin
         rsp_ff.result_value <= result_ff;
         rsp_ff.moved        <= moved_ff;
      end
   end

endmodule
